/* hdl/als_pkg.sv */
package als_pkg;

  // Sample store geometry
  localparam int unsigned SAMPLE_COUNT = 6;
  localparam int unsigned SAMPLE_BITS  = 12;

  // Port field widths
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned BL_W    = 8;
  localparam int unsigned AVG_W   = 12;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned LUX_W   = 14;
  localparam int unsigned WIDE_W  = 16;

  // Scan counter and accumulator widths
  localparam int unsigned CNT_W = $clog2(SAMPLE_COUNT);
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(SAMPLE_COUNT);

  // Reciprocal multiply for the trimmed-mean divide, exact for any SUM_W-bit value
  localparam int unsigned DIVISOR   = SAMPLE_COUNT - 2;
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(DIVISOR);
  localparam int unsigned MULT_W    = DIV_SHIFT + 1;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int unsigned PROD_W    = SUM_W + MULT_W;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEVEL_W-1:0]     level_t;

  // Levels
  localparam level_t LVL_INIT = 3'd0;
  localparam level_t LVL_1    = 3'd1;
  localparam level_t LVL_2    = 3'd2;
  localparam level_t LVL_3    = 3'd3;
  localparam level_t LVL_4    = 3'd4;
  localparam level_t LVL_5    = 3'd5;

  // Quantizer thresholds
  localparam logic [WIDE_W-1:0] TH_5   = 16'd2100;
  localparam logic [WIDE_W-1:0] TH_45  = 16'd1900;
  localparam logic [WIDE_W-1:0] TH_4   = 16'd1800;
  localparam logic [WIDE_W-1:0] TH_34  = 16'd1200;
  localparam logic [WIDE_W-1:0] TH_3   = 16'd800;
  localparam logic [WIDE_W-1:0] TH_23  = 16'd600;
  localparam logic [WIDE_W-1:0] TH_2   = 16'd400;
  localparam logic [WIDE_W-1:0] TH_12  = 16'd250;

  // Lux per level
  localparam logic [LUX_W-1:0] LUX_L5   = 14'd15000;
  localparam logic [LUX_W-1:0] LUX_L4   = 14'd9000;
  localparam logic [LUX_W-1:0] LUX_L3   = 14'd5000;
  localparam logic [LUX_W-1:0] LUX_L2   = 14'd1000;
  localparam logic [LUX_W-1:0] LUX_L1   = 14'd6;
  localparam logic [LUX_W-1:0] LUX_INIT = 14'd5000;

  // Cell control: fill loads the sample, shift takes the neighbour's value
  typedef struct packed {
    logic fill;
    logic shift;
  } cell_ctrl_t;

  // Accumulator control: start restarts on the current value, step adds it
  typedef struct packed {
    logic start;
    logic step;
  } acc_ctrl_t;

  // Hysteresis quantizer; b is the band remembered from the last item
  function automatic level_t quantize(logic [WIDE_W-1:0] m, level_t b);
    level_t lvl;
    if (m >= TH_5) begin
      lvl = LVL_5;
    end else if (m >= TH_45) begin
      lvl = (b == LVL_5) ? LVL_5 : LVL_4;
    end else if (m >= TH_4) begin
      lvl = LVL_4;
    end else if (m >= TH_34) begin
      lvl = (b >= LVL_4) ? LVL_4 : LVL_3;
    end else if (m >= TH_3) begin
      lvl = LVL_3;
    end else if (m >= TH_23) begin
      lvl = (b >= LVL_3) ? LVL_3 : LVL_2;
    end else if (m >= TH_2) begin
      lvl = LVL_2;
    end else if (m >= TH_12) begin
      lvl = (b >= LVL_2) ? LVL_2 : LVL_1;
    end else begin
      lvl = LVL_1;
    end
    return lvl;
  endfunction

  function automatic logic [LUX_W-1:0] level_lux(level_t lvl);
    logic [LUX_W-1:0] lux;
    case (lvl)
      LVL_5:   lux = LUX_L5;
      LVL_4:   lux = LUX_L4;
      LVL_3:   lux = LUX_L3;
      LVL_2:   lux = LUX_L2;
      LVL_1:   lux = LUX_L1;
      default: lux = LUX_INIT;
    endcase
    return lux;
  endfunction

endpackage

/* hdl/als_cell.sv */
module als_cell (
  input  logic                clk_i,
  input  als_pkg::cell_ctrl_t ctrl_i,
  input  als_pkg::sample_t    sample_i,
  input  als_pkg::sample_t    prev_i,
  output als_pkg::sample_t    value_o
);
  import als_pkg::*;

  sample_t value_q, value_d;

  // Load the new sample on fill, take the neighbour's value on shift, else hold
  always_comb begin
    value_d = value_q;
    if (ctrl_i.fill) begin
      value_d = sample_i;
    end else if (ctrl_i.shift) begin
      value_d = prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* hdl/als_accum.sv */
module als_accum (
  input  logic                    clk_i,
  input  als_pkg::acc_ctrl_t      ctrl_i,
  input  als_pkg::sample_t        value_i,
  output logic [als_pkg::SUM_W-1:0] sum_o,
  output als_pkg::sample_t        hi_o,
  output als_pkg::sample_t        lo_o
);
  import als_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d;
  sample_t          hi_q, hi_d, lo_q, lo_d;

  // Restart on the first value of a scan, then add and track the extremes
  always_comb begin
    sum_d = sum_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (ctrl_i.start) begin
      sum_d = SUM_W'(value_i);
      hi_d  = value_i;
      lo_d  = value_i;
    end else if (ctrl_i.step) begin
      sum_d = sum_q + SUM_W'(value_i);
      if (value_i > hi_q) hi_d = value_i;
      if (value_i < lo_q) lo_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

  assign sum_o = sum_q;
  assign hi_o  = hi_q;
  assign lo_o  = lo_q;

endmodule

/* hdl/ambient_light_level_classifier_unit.sv */
// Channel | Handshake                  | Payload
// input   | in_valid_i / in_stall_o    | adc_sample_i, backlight_now_i
// result  | out_valid_o / out_stall_i  | average_o, computed_level_o,
//         |                            | reported_level_o, lux_o
// config  | cfg_we_i                   | cfg_wdata_i (hold_level)
//
// Each item is handled in order: store the sample, take one rotation step
// per cell while the ring turns past the accumulator, then trim, reciprocal
// multiply and quantize.
// Reset clears control, band (to two), reported level (to init) and hold.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits in the quantize step until the register frees.
module ambient_light_level_classifier_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [als_pkg::ADC_W-1:0]        adc_sample_i,
  input  logic [als_pkg::BL_W-1:0]         backlight_now_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [als_pkg::AVG_W-1:0]        average_o,
  output logic [als_pkg::LEVEL_W-1:0]      computed_level_o,
  output logic [als_pkg::LEVEL_W-1:0]      reported_level_o,
  output logic [als_pkg::LUX_W-1:0]        lux_o
);
  import als_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_TRIM = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_QNT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             hold_q;
  level_t           band_q, band_d;
  level_t           held_q, held_d;
  logic [BL_W-1:0]  bl_q;
  logic [SUM_W-1:0] trim_q;
  sample_t          avg_q;

  logic             out_valid_q, out_valid_d;
  logic [AVG_W-1:0] average_q;
  level_t           comp_q, rep_q;
  logic [LUX_W-1:0] lux_q;

  logic             in_xfer, out_free, emit;
  logic [WIDE_W-1:0] adc_wide, avg_wide;
  sample_t          sample;
  sample_t          cell_q [SAMPLE_COUNT];
  sample_t          head;
  cell_ctrl_t       cell_ctrl;
  acc_ctrl_t        acc_ctrl;
  logic [SUM_W-1:0] acc_sum;
  sample_t          acc_hi, acc_lo;
  logic [PROD_W-1:0] product;
  level_t           lvl;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == ST_QNT) && out_free;

  // Drop sample bits above the stored width
  assign adc_wide = WIDE_W'(adc_sample_i);
  assign sample   = adc_wide[SAMPLE_BITS-1:0];

  // Fill every cell while init, otherwise push the sample in and rotate
  assign cell_ctrl.fill  = in_xfer && (held_q == LVL_INIT);
  assign cell_ctrl.shift = (in_xfer && (held_q != LVL_INIT)) || (state_q == ST_SCAN);
  assign head            = (state_q == ST_SCAN) ? cell_q[SAMPLE_COUNT-1] : sample;

  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      als_cell u_cell (
        .clk_i    (clk_i),
        .ctrl_i   (cell_ctrl),
        .sample_i (sample),
        .prev_i   (head),
        .value_o  (cell_q[i])
      );
    end else begin : g_body
      als_cell u_cell (
        .clk_i    (clk_i),
        .ctrl_i   (cell_ctrl),
        .sample_i (sample),
        .prev_i   (cell_q[i-1]),
        .value_o  (cell_q[i])
      );
    end
  end

  // Accumulate the tail cell as the ring rotates once around
  assign acc_ctrl.start = (state_q == ST_SCAN) && (cnt_q == '0);
  assign acc_ctrl.step  = (state_q == ST_SCAN);

  als_accum u_accum (
    .clk_i   (clk_i),
    .ctrl_i  (acc_ctrl),
    .value_i (cell_q[SAMPLE_COUNT-1]),
    .sum_o   (acc_sum),
    .hi_o    (acc_hi),
    .lo_o    (acc_lo)
  );

  // Divide by the trimmed count through the reciprocal
  assign product  = PROD_W'(trim_q) * PROD_W'(MULT_W'(DIV_MULT));
  assign avg_wide = WIDE_W'(avg_q);
  assign lvl      = quantize(avg_wide, band_q);

  // Sequence one item
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_xfer) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SAMPLE_COUNT - 1)) state_d = ST_TRIM;
      end
      ST_TRIM: state_d = ST_DIV;
      ST_DIV:  state_d = ST_QNT;
      ST_QNT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Advance band on issuing a result, and the reported level unless hold is set or backlight <= 5
  always_comb begin
    band_d = band_q;
    held_d = held_q;
    if (emit) begin
      band_d = lvl;
      if ((bl_q > BL_W'(5)) && !hold_q) held_d = lvl;
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hold_q      <= 1'b0;
      band_q      <= LVL_2;
      held_q      <= LVL_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      band_q      <= band_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) hold_q <= cfg_wdata_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) bl_q <= backlight_now_i;
    if (state_q == ST_TRIM) trim_q <= acc_sum - SUM_W'(acc_hi) - SUM_W'(acc_lo);
    if (state_q == ST_DIV) avg_q <= product[DIV_SHIFT +: SAMPLE_BITS];
    if (emit) begin
      average_q <= avg_wide[AVG_W-1:0];
      comp_q    <= lvl;
      rep_q     <= held_d;
      lux_q     <= level_lux(held_d);
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign average_o        = average_q;
  assign computed_level_o = comp_q;
  assign reported_level_o = rep_q;
  assign lux_o            = lux_q;

endmodule
